### src/mrst_pkg.sv
// Shared constants, register codes and the CORDIC angle table for the
// mixed-radix stage twiddle core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrst_pkg;

	localparam int LANE_BITS       = 12;
	localparam int LANES_BITS      = 13;
	localparam int RADIX_BITS      = 7;
	localparam int NUM_RADIX       = 4;
	localparam int COUNT_BITS      = 3;
	localparam int STAGE_BITS      = 2;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = 13;
	// product of up to three radices, and of all four
	localparam int PRE_BITS        = 3 * RADIX_BITS;
	localparam int DEN_BITS        = 4 * RADIX_BITS;
	localparam int TURN_BITS       = 32;
	localparam int CORDIC_STEPS    = 30;
	localparam int XY_BITS         = 34;
	localparam int Z_BITS          = 32;

	localparam int MAX_FACTORS_DEF = 4;
	localparam int INDEX_BITS_DEF  = 24;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam logic signed [XY_BITS-1:0] CORDIC_START = 34'sd652032874;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX_0      = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX_1      = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX_2      = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX_3      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR_COUNT = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE_SELECT = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LANE_COUNT   = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INVERSE      = 3'd7;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// atan(2^-i) as a 32-bit turn fraction
	function automatic logic [TURN_BITS-1:0] step_angle(input int unsigned i);
		logic [TURN_BITS-1:0] a;
		case (i)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

### src/mixed_radix_stage_twiddle_core.sv
// Top level of the mixed-radix stage twiddle generator.
// Depends on mrst_pkg, mrst_div and mrst_cordic.
`timescale 1ns / 1ps
`default_nettype none

// One request (lane, element) gives one twiddle for the selected FFT stage, in
// signed Q1.(SAMPLE_BITS-1), plus its table position lane + lanes * element.
// The core takes one request per clock and delivers one result per clock while
// the skid entry is empty; s_tready drops while that entry holds a result.
// The pipeline runs through three bit-serial divider pipelines (element by
// radix, codelet by the earlier-stage radix product, phase by the denominator)
// and the 30-step CORDIC rotator. A two-entry output buffer takes one extra
// result while the downstream side stalls. Decode errors return zero cos and
// sin with tuser set. Write the registers only while no request is in flight.

module mixed_radix_stage_twiddle_core #(
	parameter int MAX_FACTORS = mrst_pkg::MAX_FACTORS_DEF,
	parameter int INDEX_BITS  = mrst_pkg::INDEX_BITS_DEF,
	parameter int SAMPLE_BITS = mrst_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [mrst_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [mrst_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// lane_index, elem_index, zero fill
	input  wire logic [((mrst_pkg::LANE_BITS + INDEX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// cos_value, sin_value, table_index, zero fill
	output logic [((2 * SAMPLE_BITS + INDEX_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// decode_error
	output logic                                       m_tuser
);

	localparam int LB       = mrst_pkg::LANE_BITS;
	localparam int NB       = mrst_pkg::LANES_BITS;
	localparam int RB       = mrst_pkg::RADIX_BITS;
	localparam int PB       = mrst_pkg::PRE_BITS;
	localparam int DB       = mrst_pkg::DEN_BITS;
	localparam int TB       = mrst_pkg::TURN_BITS;
	localparam int XY       = mrst_pkg::XY_BITS;
	localparam int ZB       = mrst_pkg::Z_BITS;
	localparam int CB       = mrst_pkg::COUNT_BITS;
	localparam int REM_BITS = NB + INDEX_BITS + 1;
	localparam int OUT_BITS = 2 * SAMPLE_BITS + INDEX_BITS;
	localparam int OUT_DATA = ((OUT_BITS + 7) / 8) * 8;
	localparam int SH       = 31 - SAMPLE_BITS;
	localparam logic signed [XY:0] RND    = (XY + 1)'(1) <<< (SH - 1);
	localparam logic signed [XY:0] SAT_HI = (XY + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [XY:0] SAT_LO = -SAT_HI - (XY + 1)'(1);

	// ---------------- configuration registers ----------------
	logic [RB-1:0]                        radix_q [mrst_pkg::NUM_RADIX];
	logic [CB-1:0]                        count_q;
	logic [mrst_pkg::STAGE_BITS-1:0]      stage_q;
	logic [NB-1:0]                        lanes_q;
	logic                                 inverse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < mrst_pkg::NUM_RADIX; k++) begin
				radix_q[k] <= RB'(2);
			end
			count_q   <= CB'(1);
			stage_q   <= '0;
			lanes_q   <= NB'(1);
			inverse_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrst_pkg::REG_RADIX_0:      radix_q[0] <= cfg_data[RB-1:0];
				mrst_pkg::REG_RADIX_1:      radix_q[1] <= cfg_data[RB-1:0];
				mrst_pkg::REG_RADIX_2:      radix_q[2] <= cfg_data[RB-1:0];
				mrst_pkg::REG_RADIX_3:      radix_q[3] <= cfg_data[RB-1:0];
				mrst_pkg::REG_FACTOR_COUNT: count_q    <= cfg_data[CB-1:0];
				mrst_pkg::REG_STAGE_SELECT: stage_q    <= cfg_data[mrst_pkg::STAGE_BITS-1:0];
				mrst_pkg::REG_LANE_COUNT:   lanes_q    <= cfg_data[NB-1:0];
				mrst_pkg::REG_INVERSE:      inverse_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- derived radix products ----------------
	logic [RB-1:0] rad_eff [mrst_pkg::NUM_RADIX];
	logic [RB-1:0] pre_f   [mrst_pkg::NUM_RADIX];
	logic [RB-1:0] post_f  [mrst_pkg::NUM_RADIX];
	logic [CB-1:0] cnt_eff;
	logic [NB-1:0] lanes_eff;

	always_comb begin
		if (count_q == '0) begin
			cnt_eff = CB'(1);
		end else if (count_q > CB'(MAX_FACTORS)) begin
			cnt_eff = CB'(MAX_FACTORS);
		end else begin
			cnt_eff = count_q;
		end
		lanes_eff = (lanes_q == '0) ? NB'(1) : lanes_q;
		for (int k = 0; k < mrst_pkg::NUM_RADIX; k++) begin
			rad_eff[k] = (radix_q[k] == '0) ? RB'(1) : radix_q[k];
			pre_f[k]   = (CB'(k) < CB'(stage_q)) ? rad_eff[k] : RB'(1);
			post_f[k]  = (CB'(k) > CB'(stage_q) && CB'(k) < cnt_eff) ? rad_eff[k] : RB'(1);
		end
	end

	logic [RB-1:0]   den1_q;
	logic            stage_err_q;
	logic [2*RB-1:0] pre01_q;
	logic [RB-1:0]   pre2_q;
	logic [2*RB-1:0] post12_q;
	logic [RB-1:0]   post3_q;
	logic [RB-1:0]   rst_q;
	logic [PB-1:0]   pre_q;
	logic [PB-1:0]   post_q;
	logic [PB-1:0]   npr_q;
	logic [DB-1:0]   den_q;
	logic [2*PB-1:0] npr_full;

	assign npr_full = pre_q * post_q;

	// registered copies that lag the configuration registers; settle ahead of any request use
	always_ff @(posedge clk) begin
		den1_q      <= rad_eff[stage_q];
		stage_err_q <= CB'(stage_q) >= cnt_eff;
		pre01_q     <= pre_f[0] * pre_f[1];
		pre2_q      <= pre_f[2];
		post12_q    <= post_f[1] * post_f[2];
		post3_q     <= post_f[3];
		rst_q       <= rad_eff[stage_q];
		pre_q       <= pre01_q * pre2_q;
		post_q      <= post12_q * post3_q;
		npr_q       <= npr_full[PB-1:0];
		den_q       <= pre_q * rst_q;
	end

	// ---------------- pipeline ----------------
	logic pipe_en;
	logic skid_v_q;

	assign pipe_en  = !skid_v_q;
	assign s_tready = pipe_en;

	// s1: capture request, form table position
	logic                  v_s1;
	logic [LB-1:0]         lane_s1;
	logic [INDEX_BITS-1:0] elem_s1;
	logic [INDEX_BITS-1:0] tidx_s1;
	logic [NB+INDEX_BITS-1:0] tsum;
	logic [LB-1:0]         in_lane;
	logic [INDEX_BITS-1:0] in_elem;

	assign in_lane = s_tdata[LB-1:0];
	assign in_elem = s_tdata[LB+INDEX_BITS-1:LB];
	assign tsum    = (NB + INDEX_BITS)'(in_lane) + lanes_eff * in_elem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			lane_s1 <= in_lane;
			elem_s1 <= in_elem;
			tidx_s1 <= tsum[INDEX_BITS-1:0];
		end
	end

	// element / stage radix -> group, digit
	logic                     d1_v;
	logic [INDEX_BITS-1:0]    d1_group;
	logic [RB-1:0]            d1_digit;
	logic [INDEX_BITS+LB-1:0] d1_side;

	mrst_div #(
		.NUM_BITS  (INDEX_BITS),
		.DIV_BITS  (RB),
		.SIDE_BITS (INDEX_BITS + LB)
	) u_div_elem (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (v_s1),
		.in_rem    ('0),
		.in_num    (elem_s1),
		.in_side   ({tidx_s1, lane_s1}),
		.divisor   (den1_q),
		.out_valid (d1_v),
		.out_quo   (d1_group),
		.out_rem   (d1_digit),
		.out_side  (d1_side)
	);

	// s2: codelet
	logic                  v_s2;
	logic [REM_BITS-1:0]   code_s2;
	logic [RB-1:0]         digit_s2;
	logic [INDEX_BITS-1:0] tidx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= d1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			code_s2  <= REM_BITS'(d1_side[LB-1:0]) + lanes_eff * d1_group;
			digit_s2 <= d1_digit;
			tidx_s2  <= d1_side[INDEX_BITS+LB-1:LB];
		end
	end

	// s3: codelet must stay below the product of the other radices
	logic                  v_s3;
	logic                  err_s3;
	logic [PB-1:0]         low_s3;
	logic [RB-1:0]         digit_s3;
	logic [INDEX_BITS-1:0] tidx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (pipe_en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			err_s3   <= stage_err_q || (code_s2 >= REM_BITS'(npr_q));
			low_s3   <= code_s2[PB-1:0];
			digit_s3 <= digit_s2;
			tidx_s3  <= tidx_s2;
		end
	end

	// codelet mod earlier-stage product -> prefix
	logic                        d2_v;
	logic [PB-1:0]               d2_quo;
	logic [PB-1:0]               d2_prefix;
	logic [1+RB+INDEX_BITS-1:0]  d2_side;

	mrst_div #(
		.NUM_BITS  (PB),
		.DIV_BITS  (PB),
		.SIDE_BITS (1 + RB + INDEX_BITS)
	) u_div_prefix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (v_s3),
		.in_rem    ('0),
		.in_num    (low_s3),
		.in_side   ({err_s3, digit_s3, tidx_s3}),
		.divisor   (pre_q),
		.out_valid (d2_v),
		.out_quo   (d2_quo),
		.out_rem   (d2_prefix),
		.out_side  (d2_side)
	);

	// s4: phase numerator, already below the denominator
	logic                  v_s4;
	logic [DB-1:0]         p_s4;
	logic                  err_s4;
	logic [INDEX_BITS-1:0] tidx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (pipe_en) begin
			v_s4 <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			p_s4    <= d2_prefix * d2_side[RB+INDEX_BITS-1:INDEX_BITS];
			err_s4  <= d2_side[RB+INDEX_BITS] | (d2_quo != d2_quo);
			tidx_s4 <= d2_side[INDEX_BITS-1:0];
		end
	end

	// (p * 2^32 + denom/2) / denom -> turn fraction
	logic                  d3_v;
	logic [TB:0]           d3_turn;
	logic [DB-1:0]         d3_rem;
	logic [INDEX_BITS:0]   d3_side;

	mrst_div #(
		.NUM_BITS  (TB + 1),
		.DIV_BITS  (DB),
		.SIDE_BITS (INDEX_BITS + 1)
	) u_div_turn (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (v_s4),
		.in_rem    ({1'b0, p_s4[DB-1:1]}),
		.in_num    ({p_s4[0], {(TB - DB + 1){1'b0}}, den_q[DB-1:1]}),
		.in_side   ({err_s4, tidx_s4}),
		.divisor   (den_q),
		.out_valid (d3_v),
		.out_quo   (d3_turn),
		.out_rem   (d3_rem),
		.out_side  (d3_side)
	);

	// s5: sign, quarter fold to a residual in [-1/8, 1/8) turn
	logic                  v_s5;
	logic signed [ZB-1:0]  z_s5;
	logic [1:0]            quad_s5;
	logic                  err_s5;
	logic [INDEX_BITS-1:0] tidx_s5;
	logic [TB-1:0]         turn;

	assign turn = inverse_q ? d3_turn[TB-1:0] : (TB'(0) - d3_turn[TB-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (pipe_en) begin
			v_s5 <= d3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			z_s5    <= ZB'($signed(turn[TB-3:0]));
			quad_s5 <= turn[TB-1:TB-2] + {1'b0, turn[TB-3]};
			err_s5  <= d3_side[INDEX_BITS] | (d3_rem != d3_rem);
			tidx_s5 <= d3_side[INDEX_BITS-1:0];
		end
	end

	logic                  cr_v;
	logic signed [XY-1:0]  cr_x;
	logic signed [XY-1:0]  cr_y;
	logic [INDEX_BITS+2:0] cr_side;

	mrst_cordic #(
		.SIDE_BITS (INDEX_BITS + 3)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (v_s5),
		.in_z      (z_s5),
		.in_side   ({quad_s5, err_s5, tidx_s5}),
		.out_valid (cr_v),
		.out_x     (cr_x),
		.out_y     (cr_y),
		.out_side  (cr_side)
	);

	// s6: quarter rotation
	logic                  v_s6;
	logic signed [XY-1:0]  c_s6;
	logic signed [XY-1:0]  sn_s6;
	logic                  err_s6;
	logic [INDEX_BITS-1:0] tidx_s6;
	logic signed [XY-1:0]  rot_c;
	logic signed [XY-1:0]  rot_s;

	always_comb begin
		unique case (cr_side[INDEX_BITS+2:INDEX_BITS+1])
			mrst_pkg::QUAD_0: begin rot_c = cr_x;  rot_s = cr_y;  end
			mrst_pkg::QUAD_1: begin rot_c = -cr_y; rot_s = cr_x;  end
			mrst_pkg::QUAD_2: begin rot_c = -cr_x; rot_s = -cr_y; end
			mrst_pkg::QUAD_3: begin rot_c = cr_y;  rot_s = -cr_x; end
			default:          begin rot_c = cr_x;  rot_s = cr_y;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (pipe_en) begin
			v_s6 <= cr_v;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			c_s6    <= rot_c;
			sn_s6   <= rot_s;
			err_s6  <= cr_side[INDEX_BITS];
			tidx_s6 <= cr_side[INDEX_BITS-1:0];
		end
	end

	// s7: round half up, saturate, zero on error
	function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic signed [XY-1:0] v);
		logic signed [XY:0] r;
		r = ($signed({v[XY-1], v}) + RND) >>> SH;
		if (r > SAT_HI) begin
			r = SAT_HI;
		end else if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	logic                   v_s7;
	logic [SAMPLE_BITS-1:0] cos_s7;
	logic [SAMPLE_BITS-1:0] sin_s7;
	logic                   err_s7;
	logic [INDEX_BITS-1:0]  tidx_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (pipe_en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			cos_s7  <= err_s6 ? '0 : to_sample(c_s6);
			sin_s7  <= err_s6 ? '0 : to_sample(sn_s6);
			err_s7  <= err_s6;
			tidx_s7 <= tidx_s6;
		end
	end

	// ---------------- output register and skid ----------------
	logic [OUT_DATA-1:0] last_data;
	logic [OUT_DATA-1:0] out_data_q;
	logic [OUT_DATA-1:0] skid_data_q;
	logic                out_user_q;
	logic                skid_user_q;
	logic                out_v_q;
	logic                take;
	logic                arrive;

	assign last_data = OUT_DATA'({tidx_s7, sin_s7, cos_s7});
	assign take      = out_v_q && m_tready;
	assign arrive    = v_s7 && pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (arrive) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (arrive) begin
			if (out_v_q && !take) begin
				skid_data_q <= last_data;
				skid_user_q <= err_s7;
			end else begin
				out_data_q <= last_data;
				out_user_q <= err_s7;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// ---------------- assertions ----------------
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready && v_s7))
		else $error("skid filled without a stalled output");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[2*SAMPLE_BITS-1:0] == '0))
		else $error("decode error result carries nonzero twiddle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!pipe_en && v_s7) |=> v_s7)
		else $error("final stage dropped a result during stall");

endmodule

`default_nettype wire

### src/mrst_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Uses no package; the user must hold the divisor stable while requests are in flight (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module mrst_div #(
	parameter int NUM_BITS  = 8,
	parameter int DIV_BITS  = 8,
	parameter int SIDE_BITS = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [DIV_BITS-1:0]  in_rem,
	input  wire logic [NUM_BITS-1:0]  in_num,
	input  wire logic [SIDE_BITS-1:0] in_side,
	input  wire logic [DIV_BITS-1:0]  divisor,
	output logic                      out_valid,
	output logic [NUM_BITS-1:0]       out_quo,
	output logic [DIV_BITS-1:0]       out_rem,
	output logic [SIDE_BITS-1:0]      out_side
);

	logic                 vld_s  [1:NUM_BITS];
	logic [DIV_BITS-1:0]  rem_s  [1:NUM_BITS];
	logic [NUM_BITS-1:0]  acc_s  [1:NUM_BITS];
	logic [SIDE_BITS-1:0] side_s [1:NUM_BITS];

	for (genvar i = 0; i < NUM_BITS; i++) begin : g_step
		logic                 prev_vld;
		logic [DIV_BITS-1:0]  prev_rem;
		logic [NUM_BITS-1:0]  prev_acc;
		logic [SIDE_BITS-1:0] prev_side;
		logic [DIV_BITS:0]    cand;
		logic [DIV_BITS:0]    diff;
		logic                 ge;

		if (i == 0) begin : g_first
			assign prev_vld  = in_valid;
			assign prev_rem  = in_rem;
			assign prev_acc  = in_num;
			assign prev_side = in_side;
		end else begin : g_next
			assign prev_vld  = vld_s[i];
			assign prev_rem  = rem_s[i];
			assign prev_acc  = acc_s[i];
			assign prev_side = side_s[i];
		end

		// shift in the next numerator bit, subtract when it fits
		assign cand = {prev_rem, prev_acc[NUM_BITS-1]};
		assign ge   = cand >= {1'b0, divisor};
		assign diff = cand - {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[DIV_BITS-1:0] : cand[DIV_BITS-1:0];
				acc_s[i+1]  <= {prev_acc[NUM_BITS-2:0], ge};
				side_s[i+1] <= prev_side;
			end
		end
	end

	assign out_valid = vld_s[NUM_BITS];
	assign out_quo   = acc_s[NUM_BITS];
	assign out_rem   = rem_s[NUM_BITS];
	assign out_side  = side_s[NUM_BITS];

endmodule

`default_nettype wire

### src/mrst_cordic.sv
// Pipelined CORDIC rotator, one micro-rotation per stage, with sideband.
// Depends on mrst_pkg for widths, start gain and the angle table.
`timescale 1ns / 1ps
`default_nettype none

module mrst_cordic #(
	parameter int SIDE_BITS = 1
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_valid,
	input  wire logic signed [mrst_pkg::Z_BITS-1:0]     in_z,
	input  wire logic [SIDE_BITS-1:0]                   in_side,
	output logic                                        out_valid,
	output logic signed [mrst_pkg::XY_BITS-1:0]         out_x,
	output logic signed [mrst_pkg::XY_BITS-1:0]         out_y,
	output logic [SIDE_BITS-1:0]                        out_side
);

	localparam int N = mrst_pkg::CORDIC_STEPS;

	logic                                 vld_s  [1:N];
	logic signed [mrst_pkg::XY_BITS-1:0]  x_s    [1:N];
	logic signed [mrst_pkg::XY_BITS-1:0]  y_s    [1:N];
	logic signed [mrst_pkg::Z_BITS-1:0]   z_s    [1:N];
	logic [SIDE_BITS-1:0]                 side_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [mrst_pkg::Z_BITS-1:0] ANGLE =
			$signed(mrst_pkg::step_angle(i));
		logic                                prev_vld;
		logic signed [mrst_pkg::XY_BITS-1:0] prev_x;
		logic signed [mrst_pkg::XY_BITS-1:0] prev_y;
		logic signed [mrst_pkg::Z_BITS-1:0]  prev_z;
		logic [SIDE_BITS-1:0]                prev_side;
		logic signed [mrst_pkg::XY_BITS-1:0] dx;
		logic signed [mrst_pkg::XY_BITS-1:0] dy;

		if (i == 0) begin : g_first
			assign prev_vld  = in_valid;
			assign prev_x    = mrst_pkg::CORDIC_START;
			assign prev_y    = '0;
			assign prev_z    = in_z;
			assign prev_side = in_side;
		end else begin : g_next
			assign prev_vld  = vld_s[i];
			assign prev_x    = x_s[i];
			assign prev_y    = y_s[i];
			assign prev_z    = z_s[i];
			assign prev_side = side_s[i];
		end

		assign dx = prev_y >>> i;
		assign dy = prev_x >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= prev_vld;
			end
		end

		// rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (en) begin
				if (!prev_z[mrst_pkg::Z_BITS-1]) begin
					x_s[i+1] <= prev_x - dx;
					y_s[i+1] <= prev_y + dy;
					z_s[i+1] <= prev_z - ANGLE;
				end else begin
					x_s[i+1] <= prev_x + dx;
					y_s[i+1] <= prev_y - dy;
					z_s[i+1] <= prev_z + ANGLE;
				end
				side_s[i+1] <= prev_side;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_x     = x_s[N];
	assign out_y     = y_s[N];
	assign out_side  = side_s[N];

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for mixed_radix_stage_twiddle_core: drives requests through the stream
// port, predicts each twiddle, table position and error flag, and compares results in order.
// Depends on mrst_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

	localparam int IDX_W = 24;
	localparam int SMP_W = 16;
	localparam int CIW = mrst_pkg::CFG_INDEX_BITS;
	localparam int CDW = mrst_pkg::CFG_DATA_BITS;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [SMP_W-1:0] cos_value;
		logic signed [SMP_W-1:0] sin_value;
		logic [IDX_W-1:0] table_index;
		logic decode_error;
	} twiddle_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CIW-1:0] cfg_index = '0;
	logic [CDW-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [55:0] m_tdata;
	logic m_tuser;

	mixed_radix_stage_twiddle_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// register shadow
	logic [6:0] radix_sh [4];
	logic [2:0] count_sh;
	logic [1:0] stage_sh;
	logic [12:0] lanes_sh;
	logic inverse_sh;

	twiddle_t pending_twiddles[$];
	int mismatch_count = 0;
	bit stalls_on = 1;
	longint cycle_count = 0;

	localparam logic [31:0] ATAN_TURN [30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

	function automatic logic [SMP_W-1:0] round_q15(longint v);
		longint r;
		r = (v + (64'sd1 <<< 14)) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[SMP_W-1:0];
	endfunction

	function automatic twiddle_t predict_twiddle(logic [11:0] lane, logic [IDX_W-1:0] elem);
		twiddle_t res;
		longint unsigned r [4];
		longint unsigned cnt, lanes, radix, group, digit, rem, prefix, stride, denom, p;
		logic [31:0] turn;
		logic [1:0] quad;
		longint z, x, y, dx, dy, c, s;
		bit err;
		for (int k = 0; k < 4; k++) r[k] = radix_sh[k] ? radix_sh[k] : 1;
		cnt = count_sh == 0 ? 1 : (count_sh > 4 ? 4 : count_sh);
		lanes = lanes_sh ? lanes_sh : 1;
		res = '0;
		res.table_index = IDX_W'(lane + lanes * elem);
		err = 0;
		if (stage_sh >= cnt) err = 1;
		else begin
			radix = r[stage_sh];
			group = elem / radix;
			digit = elem % radix;
			rem = lane + lanes * group;
			prefix = 0; stride = 1; denom = 1;
			for (int k = 0; k < stage_sh; k++) begin
				prefix += (rem % r[k]) * stride;
				stride *= r[k];
				rem /= r[k];
			end
			for (int a = int'(cnt) - 1; a > int'(stage_sh); a--) rem /= r[a];
			if (rem != 0) err = 1;
			for (int k = 0; k <= stage_sh; k++) denom *= r[k];
			if (!err) begin
				p = (prefix * digit) % denom;
				turn = 32'(((p << 32) + denom / 2) / denom);
				if (!inverse_sh) turn = -turn;
				quad = turn[31:30];
				z = turn[29:0];
				if (z >= 64'sh20000000) begin
					z -= 64'sh40000000;
					quad += 1;
				end
				x = 652032874; y = 0;
				for (int i = 0; i < 30; i++) begin
					dx = y >>> i; dy = x >>> i;
					if (z >= 0) begin
						x -= dx; y += dy; z -= ATAN_TURN[i];
					end else begin
						x += dx; y -= dy; z += ATAN_TURN[i];
					end
				end
				case (quad)
					mrst_pkg::QUAD_0: begin c = x; s = y; end
					mrst_pkg::QUAD_1: begin c = -y; s = x; end
					mrst_pkg::QUAD_2: begin c = -x; s = -y; end
					default: begin c = y; s = -x; end
				endcase
				res.cos_value = round_q15(c);
				res.sin_value = round_q15(s);
			end
		end
		res.decode_error = err;
		return res;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// downstream stall bursts
	int ready_hold = 0;
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready <= 0;
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 12);
			m_tready <= 0;
		end else
			m_tready <= 1;
	end

	// compare each result with the oldest prediction; signals are stable at negedge
	always @(negedge clk) begin
		twiddle_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.cos_value = m_tdata[15:0];
			got.sin_value = m_tdata[31:16];
			got.table_index = m_tdata[55:32];
			got.decode_error = m_tuser;
			if (pending_twiddles.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result cos=%0d sin=%0d idx=%0d err=%0b",
						got.cos_value, got.sin_value, got.table_index, got.decode_error);
			end else begin
				want = pending_twiddles.pop_front();
				if (got != want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch exp cos=%0d sin=%0d idx=%0d err=%0b,",
							" got cos=%0d sin=%0d idx=%0d err=%0b"},
							want.cos_value, want.sin_value, want.table_index,
							want.decode_error, got.cos_value, got.sin_value,
							got.table_index, got.decode_error);
				end
			end
		end
	end

	// append one prediction to the tail of the queue
	task automatic queue_twiddle(twiddle_t t);
		pending_twiddles.insert(pending_twiddles.size(), t);
	endtask

	task automatic write_reg(logic [CIW-1:0] idx, logic [CDW-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			mrst_pkg::REG_RADIX_0, mrst_pkg::REG_RADIX_1,
			mrst_pkg::REG_RADIX_2, mrst_pkg::REG_RADIX_3: radix_sh[idx[1:0]] = val[6:0];
			mrst_pkg::REG_FACTOR_COUNT: count_sh = val[2:0];
			mrst_pkg::REG_STAGE_SELECT: stage_sh = val[1:0];
			mrst_pkg::REG_LANE_COUNT: lanes_sh = val[12:0];
			default: inverse_sh = val[0];
		endcase
	endtask

	// drain, then rewrite every register
	task automatic set_config(int r0, int r1, int r2, int r3, int cnt, int stg, int lanes, int inv);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_twiddles.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(mrst_pkg::REG_RADIX_0, CDW'(r0));
		write_reg(mrst_pkg::REG_RADIX_1, CDW'(r1));
		write_reg(mrst_pkg::REG_RADIX_2, CDW'(r2));
		write_reg(mrst_pkg::REG_RADIX_3, CDW'(r3));
		write_reg(mrst_pkg::REG_FACTOR_COUNT, CDW'(cnt));
		write_reg(mrst_pkg::REG_STAGE_SELECT, CDW'(stg));
		write_reg(mrst_pkg::REG_LANE_COUNT, CDW'(lanes));
		write_reg(mrst_pkg::REG_INVERSE, CDW'(inv));
		cfg_we <= 0;
	endtask

	task automatic send_request(logic [11:0] lane, logic [IDX_W-1:0] elem);
		if (stalls_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {4'b0, elem, lane};
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		queue_twiddle(predict_twiddle(lane, elem));
		@(posedge clk);
	endtask

	// request whose codelet fits the radices of the other stages
	task automatic send_valid_request();
		longint unsigned r [4], others, cnt, lanes, radix, lane, groups;
		for (int k = 0; k < 4; k++) r[k] = radix_sh[k] ? radix_sh[k] : 1;
		cnt = count_sh == 0 ? 1 : (count_sh > 4 ? 4 : count_sh);
		lanes = lanes_sh ? lanes_sh : 1;
		others = 1;
		for (int k = 0; k < cnt; k++) if (k != stage_sh) others *= r[k];
		radix = r[stage_sh];
		lane = $urandom_range(0, int'((lanes < others ? lanes : others) - 1));
		groups = (others - lane + lanes - 1) / lanes;
		if (groups == 0) groups = 1;
		send_request(lane[11:0], IDX_W'($urandom_range(0, int'(groups - 1)) * radix
			+ $urandom_range(0, int'(radix - 1))));
	endtask

	task automatic test_directed();
		send_request(12'd0, 24'd0);
		send_request(12'd1, 24'd1);
		send_request(12'hFFF, 24'hFFFFFF);
		set_config(64, 64, 64, 64, 4, 3, 1, 1);
		send_request(12'd0, 24'hFFFFFF);
		send_request(12'd0, 24'h3FFFFF);
		send_request(12'd0, 24'h000FC1);
		set_config(64, 64, 64, 64, 4, 3, 4096, 0);
		send_request(12'hFFF, 24'h000FFF);
		send_request(12'h800, 24'h000041);
		set_config(0, 3, 5, 127, 7, 2, 0, 1);
		send_request(12'd0, 24'd7);
		send_request(12'd2, 24'd9);
		set_config(4, 3, 2, 2, 0, 0, 8191, 0);
		send_request(12'hFFF, 24'd3);
		send_request(12'd5, 24'd0);
		set_config(4, 3, 5, 2, 2, 3, 3, 1);
		send_request(12'd1, 24'd2);
		set_config(8, 4, 2, 1, 3, 1, 2, 0);
		send_request(12'd1, 24'd3);
		send_request(12'd0, 24'hABCDEF);
	endtask

	task automatic test_random_phase(int items);
		int sizes;
		sizes = $urandom_range(0, 9);
		set_config(
			$urandom_range(0, 7) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 16),
			$urandom_range(0, 7) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 16),
			sizes == 0 ? 64 : $urandom_range(1, 12),
			sizes == 0 ? 64 : $urandom_range(1, 8),
			$urandom_range(0, 7) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 4),
			$urandom_range(0, 3),
			$urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 6),
			$urandom_range(0, 1));
		repeat (items) begin
			if ($urandom_range(0, 9) < 8) send_valid_request();
			else send_request(12'($urandom_range(0, 4095)),
				IDX_W'($urandom_range(0, 24'hFFFFFF)));
		end
	endtask

	initial begin
		for (int k = 0; k < 4; k++) radix_sh[k] = 2;
		count_sh = 1; stage_sh = 0; lanes_sh = 1; inverse_sh = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		repeat (30) test_random_phase(25);
		stalls_on = 0;
		test_random_phase(40);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_twiddles.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
